>>> rtl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 package
// Constants and round functions shared by the SM3 hash engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

  localparam logic [31:0] T_LOW    = 32'h79cc4519;
  localparam logic [31:0] T_HIGH   = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [3:0]  LEN_POS  = 4'd14;

  localparam logic [255:0] IV = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} << s;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/sm3_round.sv
// ----------------------------------------------------------------------------
// SM3 compression core
// Message schedule window and one compression round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_round (
  input  wire logic         clk,
  input  wire logic         start,
  input  wire logic [511:0] block,
  input  wire logic [255:0] chain,
  output logic              done,
  output logic [255:0]      result
);
  import sm3_pkg::*;

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [5:0]  rnd;
  logic        busy;
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wnew;

  always_comb begin
    tj   = (rnd < 6'd16) ? T_LOW : T_HIGH;
    a12  = rotl(v[0], 5'd12);
    ss1  = rotl(a12 + v[4] + rotl(tj, rnd[4:0]), 5'd7);
    ss2  = ss1 ^ a12;
    if (rnd < 6'd16) begin
      ff = v[0] ^ v[1] ^ v[2];
      gg = v[4] ^ v[5] ^ v[6];
    end else begin
      ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
      gg = (v[4] & v[5]) | (~v[4] & v[6]);
    end
    tt1  = ff + v[3] + ss2 + (w[0] ^ w[4]);
    tt2  = gg + v[7] + ss1 + w[0];
    wnew = perm1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v[i] <= chain[255 - 32*i -: 32];
      rnd  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
      v[0] <= tt1;
      v[1] <= v[0];
      v[2] <= rotl(v[1], 5'd9);
      v[3] <= v[2];
      v[4] <= perm0(tt2);
      v[5] <= v[4];
      v[6] <= rotl(v[5], 5'd19);
      v[7] <= v[6];
      rnd  <= rnd + 6'd1;
      done <= (rnd == 6'd63);
      if (rnd == 6'd63) begin
        busy <= 1'b0;
      end
    end else begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) result[255 - 32*i -: 32] = chain[255 - 32*i -: 32] ^ v[i];
  end

endmodule

`default_nettype wire

>>> rtl/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streams message words in, pads on the last word, emits a 256-bit digest.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one message word per handshake. tdata holds the
// big-endian word, first byte in bits 31..24; tuser holds the byte count,
// honored only on the word marked by tlast.
// Output channel (m_axis): eight digest words, most significant first,
// word index in tuser, tlast on the eighth word.
// A word that completes a 512-bit block is compressed in the shared round
// unit, one compression round per cycle, 64 rounds, plus load and fold.
// The last word runs the padding sequencer, which may compress one or two
// blocks, then the digest drains one word per cycle as the receiver takes
// it; a stalled receiver holds the current word. No input is taken while
// compressing or draining.
// Reset (rst, synchronous) loads the IV and clears counts and control;
// after the digest is sent the engine returns to that state by itself.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] data_word
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] byte_count
  input  wire logic        s_axis_tlast,   // last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_index
  output logic             m_axis_tlast    // digest_last
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {S_IN, S_COMP, S_PAD, S_OUT} state_t;

  state_t       state;
  logic [255:0] chain;
  logic [31:0]  blk [16];
  logic [3:0]   fill;
  logic [63:0]  bit_len;
  logic         pad_done;   // message end reached; remaining pushes are padding
  logic         len_phase;  // 0: zero fill only; 1: zero fill, then length words
  logic         extra_pad;  // pad byte still owed after a full last word
  logic [2:0]   oidx;
  logic         start;
  logic         done;
  logic [255:0] result;
  logic [511:0] block;
  logic [31:0]  pad_word, keep, push;
  logic [2:0]   cnt;

  sm3_round u_round (
    .clk    (clk),
    .start  (start),
    .block  (block),
    .chain  (chain),
    .done   (done),
    .result (result)
  );

  always_comb begin
    cnt  = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;
    keep = (cnt == 3'd0) ? 32'h0 : ~(32'hFFFFFFFF >> {cnt, 3'b000});
    pad_word = (s_axis_tdata & keep) | ({PAD_BYTE, 24'h0} >> {cnt, 3'b000});
    push = (s_axis_tlast && cnt != 3'd4) ? pad_word : s_axis_tdata;
    if (extra_pad) push = {PAD_BYTE, 24'h0};
    else if (len_phase && fill == LEN_POS) push = bit_len[63:32];
    else if (len_phase && fill == 4'd15) push = bit_len[31:0];
    else if (pad_done) push = 32'h0;
    // the word completing the block goes straight to the round unit
    for (int i = 0; i < 15; i++) block[511 - 32*i -: 32] = blk[i];
    block[31:0] = (fill == 4'd15) ? push : blk[15];
  end

  assign s_axis_tready = (state == S_IN) && !pad_done;
  assign start = (state == S_IN || state == S_PAD) && fill == 4'd15 &&
                 (pad_done || s_axis_tvalid);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = chain[255 - 32*oidx -: 32];
  assign m_axis_tuser  = oidx;
  assign m_axis_tlast  = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN; chain <= IV; fill <= '0; bit_len <= '0;
      pad_done <= 1'b0; len_phase <= 1'b0; extra_pad <= 1'b0; oidx <= '0;
    end else begin
      unique case (state)
        S_IN, S_PAD: begin
          if (pad_done || s_axis_tvalid) begin
            blk[fill] <= push;
            fill <= fill + 4'd1;
            if (!pad_done) begin
              pad_done  <= s_axis_tlast;
              extra_pad <= s_axis_tlast && cnt == 3'd4;
              bit_len   <= bit_len + (s_axis_tlast ? {58'd0, cnt, 3'b000} : 64'd32);
              len_phase <= s_axis_tlast && cnt != 3'd4 && fill < 4'd14;
            end else if (extra_pad) begin
              extra_pad <= 1'b0;
              len_phase <= fill < 4'd14;
            end
            if (fill == 4'd15) state <= S_COMP;
            else state <= pad_done ? S_PAD : S_IN;
          end
        end
        S_COMP: begin
          if (done) begin
            chain <= result;
            if (pad_done && len_phase && !extra_pad) begin
              state <= S_OUT;
              oidx  <= '0;
            end else begin
              state <= pad_done ? S_PAD : S_IN;
              if (pad_done && !extra_pad) len_phase <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state <= S_IN; chain <= IV; fill <= '0; bit_len <= '0;
              pad_done <= 1'b0; len_phase <= 1'b0; extra_pad <= 1'b0;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

endmodule

`default_nettype wire
